FILE: design/dwpl_pkg.sv
// ----------------------------------------------------------------------------
// dwpl_pkg: shared types and constants of the line-follow drive unit
// Field widths, command and status codes, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package dwpl_pkg;

  localparam int SensorCount = 8;
  localparam int WeightW     = 8;
  localparam int WsumW       = WeightW + $clog2(SensorCount);
  localparam int CntW        = $clog2(SensorCount + 1);
  localparam int DivStepW    = $clog2(WsumW + 1);

  localparam int EncW    = 12;
  localparam int TargetW = 12;
  localparam int GainW   = 16;
  localparam int LimW    = 20;
  localparam int RpmW    = 16;
  localparam int ErrW    = 17;
  localparam int IntW    = 24;
  localparam int PwmW    = 8;

  localparam int MulAW = 24;
  localparam int MulBW = 17;
  localparam int ProdW = MulAW + MulBW;
  localparam int AccW  = ProdW + 1;

  localparam int InDataW  = 40;
  localparam int OutDataW = 64;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  localparam logic signed [RpmW-1:0] SlowRpm = 16'sd150;
  localparam logic [PwmW-1:0]        PwmMax  = 8'd255;

  // command codes (input tuser)
  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdStop  = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  // status codes (output tuser)
  localparam logic [1:0] StatRun      = 2'd0;
  localparam logic [1:0] StatStopLine = 2'd1;
  localparam logic [1:0] StatIdle     = 2'd2;
  localparam logic [1:0] StatCmd      = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTarget   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKp       = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKi       = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLimSlow  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLimFast  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLineGain = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgScale    = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgWeights  = 3'd7;

  typedef enum logic [3:0] {
    SeqIdle,
    SeqRpmL,
    SeqRpmR,
    SeqErrL,
    SeqIntL,
    SeqKpL,
    SeqKiL,
    SeqKpR,
    SeqKiR,
    SeqAccR,
    SeqDivWait,
    SeqCorr,
    SeqFin
  } seq_state_e;

endpackage

FILE: design/dwpl_mul.sv
// ----------------------------------------------------------------------------
// dwpl_mul: shared signed multiplier with registered product
// One product per cycle; the product is registered and shows in the cycle after its operands.
// ----------------------------------------------------------------------------
module dwpl_mul (
  input  logic                                clk_i,
  input  logic signed [dwpl_pkg::MulAW-1:0]   a_i,
  input  logic signed [dwpl_pkg::MulBW-1:0]   b_i,
  output logic signed [dwpl_pkg::ProdW-1:0]   prod_o
);
  import dwpl_pkg::*;

  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] prod_q;

  assign prod_d = ProdW'(a_i) * ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

FILE: design/dwpl_div.sv
// ----------------------------------------------------------------------------
// dwpl_div: bit-serial divider for the line position
// Restoring division of a signed weight sum by the active sensor count,
// one quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module dwpl_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [dwpl_pkg::WsumW-1:0]    dividend_i,
  input  logic        [dwpl_pkg::CntW-1:0]     divisor_i,
  output logic                                 done_o,
  output logic signed [dwpl_pkg::WeightW-1:0]  quot_o
);
  import dwpl_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DivStepW-1:0]  step_q;
  logic [WsumW-1:0]     num_q;
  logic [CntW:0]        rem_q;
  logic [CntW-1:0]      div_q;
  logic                 neg_q;

  logic [CntW:0]        rem_sh;
  logic [CntW+1:0]      diff;
  logic                 ge;
  logic [WsumW-1:0]     mag;
  logic [WsumW-1:0]     quot;

  assign rem_sh = {rem_q[CntW-1:0], num_q[WsumW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_q};
  assign ge     = ~diff[CntW+1];
  assign mag    = dividend_i[WsumW-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign quot   = neg_q ? (~num_q + 1'b1) : num_q;
  assign quot_o = quot[WeightW-1:0];
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= DivStepW'(WsumW);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == DivStepW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // quotient bits shift into the dividend register from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= mag;
      rem_q <= '0;
      div_q <= divisor_i;
      neg_q <= dividend_i[WsumW-1];
    end else if (busy_q) begin
      num_q <= {num_q[WsumW-2:0], ge};
      rem_q <= ge ? diff[CntW:0] : rem_sh;
    end
  end

endmodule

FILE: design/dual_wheel_pi_line_follow_drive_unit.sv
// ----------------------------------------------------------------------------
// dual_wheel_pi_line_follow_drive_unit: two-wheel PI speed loop with line steer
// Sequencer around one shared multiplier and a bit-serial position divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the command (tick, stop, clear latch); tdata
//   carries both encoder deltas, the line-sensor bits and the link flag.
//   Output stream: one item per input item; tdata carries both duties, the
//   forward flag, the line position and both wheel speeds; tuser the status.
//   Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
//   while no item is in flight.
//   A control tick runs through every sequencer step before it shows at the
//   output; a command goes straight to the last step. The block takes one item
//   at a time and is ready again the cycle after its result is loaded. A tick's
//   run is set by the bit-serial divider for the line position (one quotient
//   bit per cycle) and by the seven passes through the one shared multiplier
//   (two speeds, two P terms, two I terms, one line correction).
//   Reset clears both integrators, the stop latch and the output valid and
//   loads the registers with their defaults.
//   A stalled receiver holds the result; the sequencer waits in its last step
//   and takes no new item until the result register frees up.
// ----------------------------------------------------------------------------
module dual_wheel_pi_line_follow_drive_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dwpl_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dwpl_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [11:0] enc_delta_left, [23:12] enc_delta_right, [31:24] sensor_bits,
  // [32] link_up, [39:33] zero
  input  logic [dwpl_pkg::InDataW-1:0]      s_axis_tdata,
  // [1:0] command
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] pwm_left, [15:8] pwm_right, [16] drive_forward, [24:17] line_position,
  // [40:25] wheel_rpm_left, [56:41] wheel_rpm_right, [63:57] zero
  output logic [dwpl_pkg::OutDataW-1:0]     m_axis_tdata,
  // [1:0] status
  output logic [1:0]                        m_axis_tuser
);
  import dwpl_pkg::*;

  // configuration
  logic [TargetW-1:0]       target_q;
  logic [GainW-1:0]         kp_q;
  logic [GainW-1:0]         ki_q;
  logic [LimW-1:0]          lim_slow_q;
  logic [LimW-1:0]          lim_fast_q;
  logic signed [GainW-1:0]  line_gain_q;
  logic [GainW-1:0]         scale_q;
  logic [CfgDataW-1:0]      weights_q;

  // latched item
  logic [1:0]               cmd_q;
  logic signed [EncW-1:0]   enc_l_q;
  logic signed [EncW-1:0]   enc_r_q;
  logic [SensorCount-1:0]   bits_q;
  logic                     link_q;

  // working values
  logic signed [RpmW-1:0]   rpm_l_q, rpm_r_q;
  logic signed [ErrW-1:0]   err_l_q, err_r_q;
  logic signed [IntW-1:0]   int_nl_q, int_nr_q;
  logic signed [AccW-1:0]   acc_l_q, acc_r_q;

  // loop state
  logic signed [IntW-1:0]   int_l_q, int_r_q;
  logic                     latch_q;
  seq_state_e               state_q, state_d;

  logic                     out_valid_q;
  logic [OutDataW-1:0]      out_data_q;
  logic [1:0]               out_user_q;

  logic                     accept;
  logic                     div_start;
  logic                     load_out;
  logic                     div_done;
  logic signed [WeightW-1:0] div_quot;
  logic signed [WeightW-1:0] pos;
  logic signed [WsumW-1:0]  wsum;
  logic [CntW-1:0]          cnt;
  logic                     all_black;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod;
  logic signed [RpmW-1:0]   rpm_sat;
  logic signed [ErrW-1:0]   target_s;
  logic [LimW-1:0]          lim;
  logic signed [AccW:0]     sum_l, sum_r;
  logic [PwmW-1:0]          pwm_l, pwm_r;

  function automatic logic signed [RpmW-1:0] sat_rpm(input logic signed [ProdW-1:0] p);
    logic [ProdW-9:0] sh;
    sh = p[ProdW-1:8];
    if (!sh[ProdW-9] && (|sh[ProdW-9:RpmW-1])) begin
      return {1'b0, {(RpmW-1){1'b1}}};
    end else if (sh[ProdW-9] && !(&sh[ProdW-9:RpmW-1])) begin
      return {1'b1, {(RpmW-1){1'b0}}};
    end else begin
      return sh[RpmW-1:0];
    end
  endfunction

  function automatic logic signed [IntW-1:0] clamp_int(
    input logic signed [IntW-1:0] acc,
    input logic signed [ErrW-1:0] err,
    input logic [LimW-1:0]        lim_v
  );
    logic signed [IntW:0] s;
    logic signed [IntW:0] lp;
    s  = (IntW+1)'(acc) + (IntW+1)'(err);
    lp = $signed({{(IntW+1-LimW){1'b0}}, lim_v});
    if (s > lp) begin
      return lp[IntW-1:0];
    end else if (s < -lp) begin
      return IntW'(-lp);
    end else begin
      return s[IntW-1:0];
    end
  endfunction

  function automatic logic [PwmW-1:0] duty(input logic signed [AccW:0] d);
    if (d[AccW]) begin
      return '0;
    end else if (|d[AccW-1:PwmW+8]) begin
      return PwmMax;
    end else begin
      return d[PwmW+7:8];
    end
  endfunction

  // line sensors: eight independent taps summed once per item
  always_comb begin
    logic signed [WeightW-1:0] w;
    wsum = '0;
    cnt  = '0;
    w    = '0;
    for (int i = 0; i < SensorCount; i++) begin
      w = weights_q[WeightW*i +: WeightW];
      if (bits_q[i]) begin
        wsum = wsum + WsumW'(w);
        cnt  = cnt + CntW'(1);
      end
    end
  end

  assign all_black = &bits_q;
  assign pos       = (cnt == '0) ? '0 : div_quot;
  assign target_s  = $signed({{(ErrW-TargetW){1'b0}}, target_q});
  assign lim       = ((rpm_l_q < SlowRpm) && (rpm_r_q < SlowRpm)) ? lim_slow_q : lim_fast_q;
  assign rpm_sat   = sat_rpm(prod);
  assign sum_l     = (AccW+1)'(acc_l_q) - (AccW+1)'(prod);
  assign sum_r     = (AccW+1)'(acc_r_q) + (AccW+1)'(prod);
  assign pwm_l     = duty(sum_l);
  assign pwm_r     = duty(sum_r);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      SeqRpmL: begin
        mul_a = MulAW'(enc_l_q);
        mul_b = $signed({1'b0, scale_q});
      end
      SeqRpmR: begin
        mul_a = MulAW'(enc_r_q);
        mul_b = $signed({1'b0, scale_q});
      end
      SeqKpL: begin
        mul_a = MulAW'(err_l_q);
        mul_b = $signed({1'b0, kp_q});
      end
      SeqKiL: begin
        mul_a = MulAW'(int_nl_q);
        mul_b = $signed({1'b0, ki_q});
      end
      SeqKpR: begin
        mul_a = MulAW'(err_r_q);
        mul_b = $signed({1'b0, kp_q});
      end
      SeqKiR: begin
        mul_a = MulAW'(int_nr_q);
        mul_b = $signed({1'b0, ki_q});
      end
      // hold the correction product steady while the output stalls
      SeqCorr, SeqFin: begin
        mul_a = MulAW'(pos);
        mul_b = MulBW'(line_gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  dwpl_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  dwpl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (wsum),
    .divisor_i  (cnt),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // sequencer
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      SeqIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = (s_axis_tuser == CmdTick) ? SeqRpmL : SeqFin;
        end
      end
      SeqRpmL: begin
        div_start = 1'b1;
        state_d   = SeqRpmR;
      end
      SeqRpmR:  state_d = SeqErrL;
      SeqErrL:  state_d = SeqIntL;
      SeqIntL:  state_d = SeqKpL;
      SeqKpL:   state_d = SeqKiL;
      SeqKiL:   state_d = SeqKpR;
      SeqKpR:   state_d = SeqKiR;
      SeqKiR:   state_d = SeqAccR;
      SeqAccR:  state_d = SeqDivWait;
      SeqDivWait: begin
        if (div_done) begin
          state_d = SeqCorr;
        end
      end
      SeqCorr:  state_d = SeqFin;
      SeqFin: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = SeqIdle;
        end
      end
      default:  state_d = SeqIdle;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      kp_q        <= GainW'(256);
      ki_q        <= '0;
      lim_slow_q  <= LimW'(4096);
      lim_fast_q  <= LimW'(8192);
      line_gain_q <= '0;
      scale_q     <= GainW'(256);
      weights_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTarget:   target_q    <= cfg_data_i[TargetW-1:0];
        CfgKp:       kp_q        <= cfg_data_i[GainW-1:0];
        CfgKi:       ki_q        <= cfg_data_i[GainW-1:0];
        CfgLimSlow:  lim_slow_q  <= cfg_data_i[LimW-1:0];
        CfgLimFast:  lim_fast_q  <= cfg_data_i[LimW-1:0];
        CfgLineGain: line_gain_q <= cfg_data_i[GainW-1:0];
        CfgScale:    scale_q     <= cfg_data_i[GainW-1:0];
        CfgWeights:  weights_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // item capture and working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= s_axis_tuser;
      enc_l_q <= s_axis_tdata[11:0];
      enc_r_q <= s_axis_tdata[23:12];
      bits_q  <= s_axis_tdata[24 +: SensorCount];
      link_q  <= s_axis_tdata[32];
    end
    case (state_q)
      SeqRpmR: rpm_l_q <= rpm_sat;
      SeqErrL: begin
        rpm_r_q <= rpm_sat;
        err_l_q <= target_s - ErrW'(rpm_l_q);
      end
      SeqIntL: begin
        err_r_q  <= target_s - ErrW'(rpm_r_q);
        int_nl_q <= clamp_int(int_l_q, err_l_q, lim);
      end
      SeqKpL:  int_nr_q <= clamp_int(int_r_q, err_r_q, lim);
      SeqKiL:  acc_l_q  <= AccW'(prod);
      SeqKpR:  acc_l_q  <= acc_l_q + AccW'(prod);
      SeqKiR:  acc_r_q  <= AccW'(prod);
      SeqAccR: acc_r_q  <= acc_r_q + AccW'(prod);
      default: ;
    endcase
  end

  // integrators, stop latch and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_l_q     <= '0;
      int_r_q     <= '0;
      latch_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
      if (cmd_q != CmdTick) begin
        if (cmd_q == CmdStop) begin
          int_l_q <= '0;
          int_r_q <= '0;
        end else if (cmd_q == CmdClear) begin
          latch_q <= 1'b0;
        end
      end else if (all_black || latch_q) begin
        latch_q <= 1'b1;
        int_l_q <= '0;
        int_r_q <= '0;
      end else if (!link_q || (target_q == '0)) begin
        int_l_q <= '0;
        int_r_q <= '0;
      end else begin
        int_l_q <= int_nl_q;
        int_r_q <= int_nr_q;
      end
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (cmd_q != CmdTick) begin
        out_data_q <= '0;
        out_user_q <= StatCmd;
      end else if (all_black || latch_q) begin
        out_data_q <= {7'b0, rpm_r_q, rpm_l_q, pos, 1'b0, {PwmW{1'b0}}, {PwmW{1'b0}}};
        out_user_q <= StatStopLine;
      end else if (!link_q || (target_q == '0)) begin
        out_data_q <= {7'b0, rpm_r_q, rpm_l_q, pos, 1'b0, {PwmW{1'b0}}, {PwmW{1'b0}}};
        out_user_q <= StatIdle;
      end else begin
        out_data_q <= {7'b0, rpm_r_q, rpm_l_q, pos, 1'b1, pwm_r, pwm_l};
        out_user_q <= StatRun;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

FILE: design/dwpl_chk.sv
// ----------------------------------------------------------------------------
// dwpl_chk: port-level checks of the line-follow drive unit
// Watches both stream channels and binds to the top level.
// ----------------------------------------------------------------------------
module dwpl_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [dwpl_pkg::OutDataW-1:0]     m_axis_tdata,
  input logic [1:0]                        m_axis_tuser
);
  import dwpl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one item at a time: ready drops after an item is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while another is in flight");

  a_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == StatCmd) |-> (m_axis_tdata == '0))
    else $error("command result carries data");

  a_halt_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != StatRun) |-> (m_axis_tdata[16:0] == '0))
    else $error("drive enabled outside run");

  a_run_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == StatRun) |-> m_axis_tdata[16])
    else $error("run result without forward drive");

endmodule

bind dual_wheel_pi_line_follow_drive_unit dwpl_chk u_dwpl_chk (.*);
